// File: hw/rtl/ffs_pkg.sv
package ffs_pkg;

  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_IGNORED     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DUPLICATE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CANCEL      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BUFFERED    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_START       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TRANSMIT    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_IDLE_EXPIRY = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_X         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MAX      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CAP     = 3'd6;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // Window tag: valid bit above the full sequence number.
  localparam int TAG_W = 17;

  // Per-source record kept in the source memory.
  typedef struct packed {
    logic        fwd;
    logic        tmr;
    logic        pnd;
    logic [31:0] allowed;
    logic [15:0] seq;
    logic [15:0] hops;
    logic [31:0] stamp;
    logic [15:0] ox;
    logic [15:0] oy;
  } src_entry_t;

endpackage

// File: hw/rtl/flood_forward_scheduler_unit.sv
// Flood forward scheduler.
// The input channel (in_valid_i / in_ready_o) carries one beat per packet arrival
// (op 0) or forward-timer expiry (op 1). Every accepted beat yields exactly one
// result beat on the output channel (out_valid_o / out_ready_i), in order.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i
// while the block is idle; the user must keep to this, the block does not enforce it.
// A write takes effect at once. A dropped, duplicate, cancelling or idle-expiry
// beat is settled in the evaluate state. An expiry that transmits forms the cooldown
// on the shared 32 by 16 multiplier. A new packet runs the radix-2 divider that
// scales the contention wait over 16 quotient bits, unless the sender sits at zero
// distance, outside the range cap or the cap is zero. The block handles one beat
// at a time, taking no new beat until the previous one reaches the output register.
// After reset the duplicate window memory is swept clear, one slot per cycle,
// over SOURCES * SEQ_WINDOW slots (16384 at the defaults); in_ready_o stays low
// until the sweep is done. Per-source state is cleared at once by valid flops.
// The result sits in an output register, so a stalled receiver holds only that
// beat: the next input beat is accepted and processed meanwhile, and waits only
// if it finishes while the previous result is still not taken.
module flood_forward_scheduler_unit #(
  parameter int SOURCES        = 64,
  parameter int SEQ_WINDOW     = 256,
  parameter int DECAY_EXPONENT = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ffs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [5:0]                      source_i,
  input  logic [15:0]                     sequence_number_i,
  input  logic [15:0]                     hops_i,
  input  logic [31:0]                     origin_stamp_i,
  input  logic signed [15:0]              origin_x_i,
  input  logic signed [15:0]              origin_y_i,
  input  logic signed [15:0]              relay_x_i,
  input  logic signed [15:0]              relay_y_i,
  input  logic [31:0]                     now_i,
  input  logic [7:0]                      jitter_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ffs_pkg::ACT_W-1:0]       action_o,
  output logic [31:0]                     delay_o,
  output logic [5:0]                      out_source_o,
  output logic [15:0]                     out_sequence_o,
  output logic [15:0]                     out_hops_o,
  output logic [31:0]                     out_stamp_o,
  output logic signed [15:0]              out_origin_x_o,
  output logic signed [15:0]              out_origin_y_o,
  output logic signed [15:0]              out_relay_x_o,
  output logic signed [15:0]              out_relay_y_o
);
  import ffs_pkg::*;

  // SEQ_WINDOW must be a power of two; the slot is taken from the low sequence bits.
  localparam int SRC_W     = $clog2(SOURCES);
  localparam int SEQ_W     = $clog2(SEQ_WINDOW);
  localparam int WIN_AW    = SRC_W + SEQ_W;
  localparam int WIN_DEPTH = SOURCES * SEQ_WINDOW;
  localparam int EXP_W     = $clog2(DECAY_EXPONENT + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EVAL  = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_ARRF  = 4'd5;
  localparam logic [3:0] ST_DECAY = 4'd6;
  localparam logic [3:0] ST_EXPF  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [5:0]  own_id_q;
  logic [15:0] own_x_q, own_y_q, base_q, wait_min_q, wait_max_q;
  logic [11:0] range_cap_q;

  // Memories: duplicate window and per-source records.
  logic [TAG_W-1:0] win_mem [WIN_DEPTH];
  src_entry_t       src_mem [SOURCES];
  logic [SOURCES-1:0] src_vld_q;

  logic              clr_q;
  logic [WIN_AW-1:0] clr_cnt_q;

  // Latched item.
  logic        op_q, src_ok_q, hit_q;
  logic [5:0]  src_q;
  logic [15:0] seq_q, hops_q, ox_q, oy_q, sx_q, sy_q;
  logic [31:0] stamp_q, now_q;
  logic [7:0]  jit_q;
  logic [TAG_W-1:0] win_rd_q;
  src_entry_t       src_rd_q;

  // Arithmetic registers.
  logic [31:0] sqx_q, sqy_q;
  logic [23:0] maxd2_q, d2_q, div_r_q;
  logic [15:0] span_q, div_lo_q, cut_q, nh_q;
  logic [3:0]  div_cnt_q;
  logic [31:0] p_q;
  logic        psat_q;
  logic [EXP_W-1:0] k_q;

  // Result.
  logic [ACT_W-1:0] res_act_q, res_act_d;
  logic [31:0]      res_delay_q, res_delay_d;
  logic             res_set;
  logic             out_valid_q;

  logic [8:0]        src_ext, src_q_ext;
  logic [SRC_W-1:0]  src_ra, src_idx;
  logic [WIN_AW-1:0] win_ra;
  logic              acc;

  src_entry_t        ent, src_wd;
  logic              src_we, win_we;
  logic [WIN_AW-1:0] win_wa;
  logic [TAG_W-1:0]  win_wd;

  logic signed [16:0] dx, dy;
  logic signed [33:0] sqx_full, sqy_full;
  logic [23:0] maxd2;
  logic [15:0] span;
  logic [32:0] d2;
  logic [39:0] prod_div;
  logic [47:0] prod_dec;
  logic [15:0] mul_b;
  logic [24:0] r2;
  logic        div_ge;
  logic        tag_hit, match;
  logic [32:0] end_sum;
  logic [31:0] cool;
  logic [33:0] base_sum;
  logic [15:0] wait_v;

  assign src_ext    = 9'(source_i);
  assign src_ra     = src_ext[SRC_W-1:0];
  assign win_ra     = {src_ra, sequence_number_i[SEQ_W-1:0]};
  assign in_ready_o = (state_q == ST_IDLE) && !clr_q;
  assign acc        = in_valid_i && in_ready_o;
  assign src_q_ext  = 9'(src_q);
  assign src_idx    = src_q_ext[SRC_W-1:0];

  // A record whose valid flop is clear reads with its flags and allowed time cleared.
  always_comb begin
    ent = src_rd_q;
    if (!hit_q) begin
      ent.fwd     = 1'b0;
      ent.tmr     = 1'b0;
      ent.pnd     = 1'b0;
      ent.allowed = '0;
    end
  end

  assign tag_hit = win_rd_q[TAG_W-1] && (win_rd_q[15:0] == seq_q);
  assign match   = ent.tmr && ent.pnd && (ent.seq == seq_q);

  assign dx       = $signed({own_x_q[15], own_x_q}) - $signed({sx_q[15], sx_q});
  assign dy       = $signed({own_y_q[15], own_y_q}) - $signed({sy_q[15], sy_q});
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign maxd2    = range_cap_q * range_cap_q;
  assign span     = (wait_max_q > wait_min_q) ? (wait_max_q - wait_min_q) : 16'd0;
  assign d2       = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign prod_div = span_q * d2_q;
  assign mul_b    = (k_q < EXP_W'(DECAY_EXPONENT)) ? nh_q : base_q;
  assign prod_dec = p_q * mul_b;
  assign r2       = {div_r_q, div_lo_q[15]};
  assign div_ge   = r2 >= {1'b0, maxd2_q};
  assign end_sum  = {1'b0, now_q} + {1'b0, p_q};
  assign cool     = (ent.fwd && (now_q < ent.allowed)) ? (ent.allowed - now_q) : 32'd0;
  assign wait_v   = wait_max_q - cut_q;
  assign base_sum = {2'b0, cool} + 34'(wait_v) + 34'(jit_q);

  always_comb begin
    state_d     = state_q;
    src_we      = 1'b0;
    src_wd      = ent;
    win_we      = 1'b0;
    win_wa      = clr_cnt_q;
    win_wd      = '0;
    res_set     = 1'b0;
    res_act_d   = ACT_IGNORED;
    res_delay_d = '0;
    if (clr_q) begin
      win_we = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_OUT;
        res_set = 1'b1;
        if (!src_ok_q) begin
          res_act_d = ACT_IGNORED;
        end else if (op_q) begin
          if (!ent.pnd || !ent.tmr) begin
            src_we     = 1'b1;
            src_wd.tmr = 1'b0;
            res_act_d  = ACT_IDLE_EXPIRY;
          end else begin
            res_set = 1'b0;
            state_d = ST_DECAY;
          end
        end else if (src_q == own_id_q) begin
          res_act_d = ACT_IGNORED;
        end else begin
          if (!tag_hit) begin
            win_we = 1'b1;
            win_wa = {src_idx, seq_q[SEQ_W-1:0]};
            win_wd = {1'b1, seq_q};
          end
          if (match) begin
            src_we     = 1'b1;
            src_wd.tmr = 1'b0;
            src_wd.pnd = 1'b0;
            res_act_d  = ACT_CANCEL;
          end else if (tag_hit) begin
            res_act_d = ACT_DUPLICATE;
          end else begin
            res_set = 1'b0;
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if ((d2 == 33'd0) || (maxd2_q == 24'd0) || (d2 > {9'd0, maxd2_q})) begin
          state_d = ST_ARRF;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == 4'd15) begin
          state_d = ST_ARRF;
        end
      end
      ST_ARRF: begin
        src_we      = 1'b1;
        src_wd.tmr  = 1'b1;
        src_wd.pnd  = 1'b1;
        src_wd.seq  = seq_q;
        src_wd.hops = hops_q;
        src_wd.stamp = stamp_q;
        src_wd.ox   = ox_q;
        src_wd.oy   = oy_q;
        res_set     = 1'b1;
        state_d     = ST_OUT;
        if (ent.tmr) begin
          res_act_d = ACT_BUFFERED;
        end else begin
          res_act_d   = ACT_START;
          res_delay_d = (base_sum[33:32] != 2'd0) ? SAT32 : base_sum[31:0];
        end
      end
      ST_DECAY: begin
        if (k_q == EXP_W'(DECAY_EXPONENT)) begin
          state_d = ST_EXPF;
        end
      end
      ST_EXPF: begin
        src_we         = 1'b1;
        src_wd.fwd     = 1'b1;
        src_wd.tmr     = 1'b0;
        src_wd.pnd     = 1'b0;
        src_wd.allowed = end_sum[32] ? SAT32 : end_sum[31:0];
        res_set        = 1'b1;
        res_act_d      = ACT_TRANSMIT;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      src_vld_q   <= '0;
      out_valid_q <= 1'b0;
      own_id_q    <= 6'd1;
      own_x_q     <= 16'd0;
      own_y_q     <= 16'd0;
      base_q      <= 16'd500;
      wait_min_q  <= 16'd5;
      wait_max_q  <= 16'd300;
      range_cap_q <= 12'd50;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == WIN_AW'(WIN_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (src_we) begin
        src_vld_q[src_idx] <= 1'b1;
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OWN_ID:        own_id_q    <= cfg_data_i[5:0];
          CFG_OWN_X:         own_x_q     <= cfg_data_i;
          CFG_OWN_Y:         own_y_q     <= cfg_data_i;
          CFG_BASE_INTERVAL: base_q      <= cfg_data_i;
          CFG_WAIT_MIN:      wait_min_q  <= cfg_data_i;
          CFG_WAIT_MAX:      wait_max_q  <= cfg_data_i;
          CFG_RANGE_CAP:     range_cap_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end

  // Memories, with registered reads taken when a beat is accepted.
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_wa] <= win_wd;
    end
    if (acc) begin
      win_rd_q <= win_mem[win_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_idx] <= src_wd;
    end
    if (acc) begin
      src_rd_q <= src_mem[src_ra];
      hit_q    <= src_vld_q[src_ra];
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q     <= op_i;
      src_q    <= source_i;
      src_ok_q <= (source_i != 6'd0) && (src_ext < 9'(SOURCES));
      seq_q    <= sequence_number_i;
      hops_q   <= hops_i;
      stamp_q  <= origin_stamp_i;
      ox_q     <= origin_x_i;
      oy_q     <= origin_y_i;
      sx_q     <= relay_x_i;
      sy_q     <= relay_y_i;
      now_q    <= now_i;
      jit_q    <= jitter_i;
    end
    if (state_q == ST_EVAL) begin
      sqx_q   <= sqx_full[31:0];
      sqy_q   <= sqy_full[31:0];
      maxd2_q <= maxd2;
      span_q  <= span;
      cut_q   <= '0;
      nh_q    <= ent.hops + 16'd1;
      p_q     <= 32'd1;
      psat_q  <= 1'b0;
      k_q     <= '0;
    end
    if (state_q == ST_SQ) begin
      d2_q <= d2[23:0];
      // Beyond range the wait drops to its floor; at zero distance it stays at the top.
      if (d2 != 33'd0) begin
        cut_q <= span_q;
      end
    end
    if (state_q == ST_MUL) begin
      // Quotient fits 16 bits, so the upper bits start below the divisor.
      div_r_q   <= prod_div[39:16];
      div_lo_q  <= prod_div[15:0];
      div_cnt_q <= '0;
    end
    if (state_q == ST_DIV) begin
      div_r_q   <= div_ge ? 24'(r2 - {1'b0, maxd2_q}) : r2[23:0];
      div_lo_q  <= {div_lo_q[14:0], div_ge};
      div_cnt_q <= div_cnt_q + 4'd1;
      if (div_cnt_q == 4'd15) begin
        cut_q <= {div_lo_q[14:0], div_ge};
      end
    end
    if (state_q == ST_DECAY) begin
      k_q <= k_q + 1'b1;
      if (k_q < EXP_W'(DECAY_EXPONENT)) begin
        if (prod_dec[47:32] != 16'd0) begin
          p_q    <= SAT32;
          psat_q <= 1'b1;
        end else begin
          p_q <= prod_dec[31:0];
        end
      end else if (!psat_q) begin
        // A power that already overflowed stays saturated whatever the interval.
        p_q <= (prod_dec[47:32] != 16'd0) ? SAT32 : prod_dec[31:0];
      end
    end
    if (res_set) begin
      res_act_q   <= res_act_d;
      res_delay_q <= res_delay_d;
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      action_o     <= res_act_q;
      delay_o      <= res_delay_q;
      out_source_o <= src_q;
      if (res_act_q == ACT_TRANSMIT) begin
        out_sequence_o <= src_rd_q.seq;
        out_hops_o     <= nh_q;
        out_stamp_o    <= src_rd_q.stamp;
        out_origin_x_o <= src_rd_q.ox;
        out_origin_y_o <= src_rd_q.oy;
        out_relay_x_o  <= own_x_q;
        out_relay_y_o  <= own_y_q;
      end else begin
        out_sequence_o <= '0;
        out_hops_o     <= '0;
        out_stamp_o    <= '0;
        out_origin_x_o <= '0;
        out_origin_y_o <= '0;
        out_relay_x_o  <= '0;
        out_relay_y_o  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
